>>> hw/rtl/qbk_pkg.sv
// ----------------------------------------------------------------------------
// qbk_pkg
// Shared widths, register codes, reset values and types of the descriptor
// bucket key block.
// ----------------------------------------------------------------------------
`default_nettype none

package qbk_pkg;

   localparam int MAX_BUCKETS_DEF = 8;
   localparam int MAX_COLUMNS_DEF = 256;

   localparam int VAL_W      = 32;
   localparam int SUM_W      = 40;
   localparam int CNT_W      = 9;
   localparam int WIN_W      = 8;
   localparam int BKT_REG_W  = 4;
   localparam int KEY_W      = 9;
   localparam int TABLE_W    = 2;
   localparam int CIDX_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TABLE_W-1:0] TABLE_LEFT  = 2'd0;
   localparam logic [TABLE_W-1:0] TABLE_D0    = 2'd1;
   localparam logic [TABLE_W-1:0] TABLE_RIGHT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKETS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_FIRST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_LAST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_FIRST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_LAST  = 3'd4;

   localparam logic [BKT_REG_W-1:0] BUCKETS_RST     = 4'd8;
   localparam logic [WIN_W-1:0]     LEFT_FIRST_RST  = 8'd1;
   localparam logic [WIN_W-1:0]     LEFT_LAST_RST   = 8'd5;
   localparam logic [WIN_W-1:0]     RIGHT_FIRST_RST = 8'd175;
   localparam logic [WIN_W-1:0]     RIGHT_LAST_RST  = 8'd179;

   typedef struct packed {
      logic [BKT_REG_W-1:0] bucket_count;
      logic [WIN_W-1:0]     left_first;
      logic [WIN_W-1:0]     left_last;
      logic [WIN_W-1:0]     right_first;
      logic [WIN_W-1:0]     right_last;
   } cfg_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] left_sum;
      logic [CNT_W-1:0]        left_count;
      logic signed [SUM_W-1:0] right_sum;
      logic [CNT_W-1:0]        right_count;
      logic signed [VAL_W-1:0] d0;
   } job_type;

   typedef struct packed {
      logic                    valid;
      logic [TABLE_W-1:0]      table_sel;
      logic [CIDX_W-1:0]       index;
      logic signed [VAL_W-1:0] value;
   } cut_write_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVIDE,
      S_SEARCH,
      S_KEY,
      S_EMIT
   } back_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/qbk_if.sv
// ----------------------------------------------------------------------------
// qbk_if
// Request, response and register write channels of the bucket key block.
// ----------------------------------------------------------------------------
`default_nettype none

interface qbk_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     cmd;
   logic signed [qbk_pkg::VAL_W-1:0]         value;
   logic                                     last;
   logic [qbk_pkg::TABLE_W-1:0]              cut_table;
   logic [qbk_pkg::CIDX_W-1:0]               cut_index;

   modport source (output valid, cmd, value, last, cut_table, cut_index, input ready);
   modport sink   (input valid, cmd, value, last, cut_table, cut_index, output ready);
endinterface

interface qbk_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [qbk_pkg::KEY_W-1:0]                bucket_key;
   logic signed [qbk_pkg::VAL_W-1:0]         left_feature;
   logic signed [qbk_pkg::VAL_W-1:0]         d0_feature;
   logic signed [qbk_pkg::VAL_W-1:0]         right_feature;

   modport source (output valid, bucket_key, left_feature, d0_feature, right_feature,
                   input ready);
   modport sink   (input valid, bucket_key, left_feature, d0_feature, right_feature,
                   output ready);
endinterface

interface qbk_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [qbk_pkg::CSR_IDX_W-1:0]            index;
   logic [qbk_pkg::CSR_DATA_W-1:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qbk_front.sv
// ----------------------------------------------------------------------------
// qbk_front
// Accepts descriptor elements and cut writes, accumulates the window sums and
// counts, and hands each finished descriptor to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qbk_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   qbk_req_if.sink                        req_bus,
   input  wire qbk_pkg::cfg_type          cfg,
   input  wire qbk_pkg::queue_status_type q_status,
   input  wire logic                      back_idle,
   output logic                           push,
   output qbk_pkg::job_type               job,
   output qbk_pkg::cut_write_type         cut_wr
);

   localparam int COL_W = $clog2(qbk_pkg::MAX_COLUMNS_DEF + 1);
   localparam int CMP_W = (COL_W > qbk_pkg::WIN_W) ? COL_W : qbk_pkg::WIN_W;

   logic [COL_W-1:0]                  col_ff, col_in, col_new;
   logic signed [qbk_pkg::SUM_W-1:0]  lsum_ff, lsum_in, lsum_new;
   logic signed [qbk_pkg::SUM_W-1:0]  rsum_ff, rsum_in, rsum_new;
   logic [qbk_pkg::CNT_W-1:0]         lcnt_ff, lcnt_in, lcnt_new;
   logic [qbk_pkg::CNT_W-1:0]         rcnt_ff, rcnt_in, rcnt_new;
   logic signed [qbk_pkg::VAL_W-1:0]  first_ff, first_in, first_new;
   logic signed [qbk_pkg::SUM_W-1:0]  v_ext;
   logic [CMP_W-1:0]                  col_cmp;
   logic                              accept, elem, in_range, nonzero, hit_l, hit_r;

   assign req_bus.ready = !q_status.full &&
                          (!req_bus.cmd || (q_status.empty && back_idle));

   always_comb begin
      accept   = req_bus.valid && req_bus.ready;
      elem     = accept && !req_bus.cmd;
      in_range = col_ff < COL_W'(qbk_pkg::MAX_COLUMNS_DEF);
      col_cmp  = CMP_W'(col_ff);
      nonzero  = req_bus.value != '0;
      v_ext    = $signed({{(qbk_pkg::SUM_W - qbk_pkg::VAL_W){req_bus.value[qbk_pkg::VAL_W-1]}},
                          req_bus.value});
      hit_l    = in_range && nonzero &&
                 (col_cmp >= CMP_W'(cfg.left_first)) && (col_cmp <= CMP_W'(cfg.left_last));
      hit_r    = in_range && nonzero &&
                 (col_cmp >= CMP_W'(cfg.right_first)) && (col_cmp <= CMP_W'(cfg.right_last));

      lsum_new  = hit_l ? lsum_ff + v_ext : lsum_ff;
      lcnt_new  = hit_l ? lcnt_ff + 1'b1 : lcnt_ff;
      rsum_new  = hit_r ? rsum_ff + v_ext : rsum_ff;
      rcnt_new  = hit_r ? rcnt_ff + 1'b1 : rcnt_ff;
      first_new = (in_range && col_ff == '0) ? req_bus.value : first_ff;
      col_new   = in_range ? col_ff + 1'b1 : col_ff;

      lsum_in  = lsum_ff;
      lcnt_in  = lcnt_ff;
      rsum_in  = rsum_ff;
      rcnt_in  = rcnt_ff;
      first_in = first_ff;
      col_in   = col_ff;
      if (elem) begin
         if (req_bus.last) begin
            lsum_in  = '0;
            lcnt_in  = '0;
            rsum_in  = '0;
            rcnt_in  = '0;
            first_in = '0;
            col_in   = '0;
         end else begin
            lsum_in  = lsum_new;
            lcnt_in  = lcnt_new;
            rsum_in  = rsum_new;
            rcnt_in  = rcnt_new;
            first_in = first_new;
            col_in   = col_new;
         end
      end

      push            = elem && req_bus.last;
      job.left_sum    = lsum_new;
      job.left_count  = lcnt_new;
      job.right_sum   = rsum_new;
      job.right_count = rcnt_new;
      job.d0          = first_new;

      cut_wr.valid     = accept && req_bus.cmd;
      cut_wr.table_sel = req_bus.cut_table;
      cut_wr.index     = req_bus.cut_index;
      cut_wr.value     = req_bus.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         lsum_ff  <= '0;
         lcnt_ff  <= '0;
         rsum_ff  <= '0;
         rcnt_ff  <= '0;
         first_ff <= '0;
      end else begin
         col_ff   <= col_in;
         lsum_ff  <= lsum_in;
         lcnt_ff  <= lcnt_in;
         rsum_ff  <= rsum_in;
         rcnt_ff  <= rcnt_in;
         first_ff <= first_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/qbk_fifo.sv
// ----------------------------------------------------------------------------
// qbk_fifo
// Short job queue between the accumulating front and the computing back.
// ----------------------------------------------------------------------------
`default_nettype none

module qbk_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire qbk_pkg::job_type          push_job,
   input  wire logic                      pop,
   output qbk_pkg::job_type               head_job,
   output qbk_pkg::queue_status_type      q_status
);

   localparam int PTR_W   = (qbk_pkg::QUEUE_DEPTH > 1) ? $clog2(qbk_pkg::QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(qbk_pkg::QUEUE_DEPTH + 1);

   qbk_pkg::job_type    mem_ff [qbk_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   always_comb begin
      q_status.full  = count_ff == COUNT_W'(qbk_pkg::QUEUE_DEPTH);
      q_status.empty = count_ff == '0;
      head_job       = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(qbk_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(qbk_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/qbk_div.sv
// ----------------------------------------------------------------------------
// qbk_div
// Signed window sum by element count, one quotient bit per cycle, truncating
// toward zero; a zero count gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module qbk_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic signed [qbk_pkg::SUM_W-1:0] dividend,
   input  wire logic [qbk_pkg::CNT_W-1:0]        divisor,
   output logic                                  busy,
   output logic signed [qbk_pkg::VAL_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(qbk_pkg::SUM_W);

   logic [qbk_pkg::SUM_W-1:0]  quo_ff, mag;
   logic [qbk_pkg::CNT_W-1:0]  rem_ff, dvs_ff;
   logic [qbk_pkg::CNT_W:0]    shifted, rem_next;
   logic [STEP_W-1:0]          step_ff;
   logic [qbk_pkg::VAL_W-1:0]  q_low;
   logic                       active_ff, neg_ff, zero_ff, fits;

   always_comb begin
      mag      = dividend[qbk_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
      shifted  = {rem_ff, quo_ff[qbk_pkg::SUM_W-1]};
      fits     = shifted >= {1'b0, dvs_ff};
      rem_next = fits ? shifted - {1'b0, dvs_ff} : shifted;
      q_low    = quo_ff[qbk_pkg::VAL_W-1:0];
      quotient = zero_ff ? '0 : (neg_ff ? $signed(~q_low + 1'b1) : $signed(q_low));
      busy     = active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (start) begin
         active_ff <= 1'b1;
      end else if (active_ff && step_ff == STEP_W'(qbk_pkg::SUM_W - 1)) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= mag;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         neg_ff  <= dividend[qbk_pkg::SUM_W-1];
         zero_ff <= divisor == '0;
         step_ff <= '0;
      end else if (active_ff) begin
         quo_ff  <= {quo_ff[qbk_pkg::SUM_W-2:0], fits};
         rem_ff  <= rem_next[qbk_pkg::CNT_W-1:0];
         step_ff <= step_ff + 1'b1;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/qbk_back.sv
// ----------------------------------------------------------------------------
// qbk_back
// Takes finished descriptors from the queue, forms the window means, counts
// cuts per table, builds the bucket key and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module qbk_back #(
   parameter int MAX_BUCKETS = qbk_pkg::MAX_BUCKETS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [qbk_pkg::BKT_REG_W-1:0]      bucket_count,
   input  wire qbk_pkg::job_type                   head_job,
   input  wire qbk_pkg::queue_status_type          q_status,
   input  wire qbk_pkg::cut_write_type             cut_wr,
   output logic                                    pop,
   output logic                                    back_idle,
   qbk_rsp_if.source                               rsp_bus
);

   localparam int CUTS = MAX_BUCKETS - 1;
   localparam int IW   = (CUTS > 1) ? $clog2(CUTS) : 1;
   localparam int CIW  = $clog2(MAX_BUCKETS);
   localparam int BW   = $clog2(MAX_BUCKETS + 1);
   localparam int TW   = CIW + BW + 1;
   localparam int KW   = TW + BW + 1;

   qbk_pkg::back_state_type state_ff, state_in;

   logic signed [qbk_pkg::VAL_W-1:0] cut_l_ff [CUTS];
   logic signed [qbk_pkg::VAL_W-1:0] cut_0_ff [CUTS];
   logic signed [qbk_pkg::VAL_W-1:0] cut_r_ff [CUTS];

   logic signed [qbk_pkg::VAL_W-1:0] lf, rf, d0_ff;
   logic [BW-1:0]                    beff, beff_ff;
   logic [CIW-1:0]                   idx_ff, bl_ff, b0_ff, br_ff;
   logic [TW-1:0]                    t_ff;
   logic [qbk_pkg::KEY_W-1:0]        key_ff;
   logic signed [qbk_pkg::VAL_W-1:0] lf_ff, d0_out_ff, rf_ff;
   logic                             rsp_valid_ff;
   logic                             l_busy, r_busy, out_free, last_cut;
   logic                             search_step, key_step, load_out, cut_ok;

   qbk_div u_div_left (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .dividend (head_job.left_sum),
      .divisor  (head_job.left_count),
      .busy     (l_busy),
      .quotient (lf)
   );

   qbk_div u_div_right (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .dividend (head_job.right_sum),
      .divisor  (head_job.right_count),
      .busy     (r_busy),
      .quotient (rf)
   );

   always_comb begin
      if (bucket_count < 4'd2) begin
         beff = BW'(2);
      end else if (int'(bucket_count) > MAX_BUCKETS) begin
         beff = BW'(MAX_BUCKETS);
      end else begin
         beff = BW'(bucket_count);
      end
      out_free = !rsp_valid_ff || rsp_bus.ready;
      last_cut = BW'(idx_ff) == beff_ff - BW'(2);
      cut_ok   = cut_wr.valid && (int'(cut_wr.index) < CUTS);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qbk_pkg::S_IDLE: begin
            if (!q_status.empty) begin
               state_in = qbk_pkg::S_DIVIDE;
            end
         end
         qbk_pkg::S_DIVIDE: begin
            if (!l_busy && !r_busy) begin
               state_in = qbk_pkg::S_SEARCH;
            end
         end
         qbk_pkg::S_SEARCH: begin
            if (last_cut) begin
               state_in = qbk_pkg::S_KEY;
            end
         end
         qbk_pkg::S_KEY: begin
            state_in = qbk_pkg::S_EMIT;
         end
         qbk_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = qbk_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = qbk_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      back_idle   = 1'b0;
      search_step = 1'b0;
      key_step    = 1'b0;
      load_out    = 1'b0;
      case (state_ff)
         qbk_pkg::S_IDLE: begin
            back_idle = 1'b1;
            pop       = !q_status.empty;
         end
         qbk_pkg::S_SEARCH: begin
            search_step = 1'b1;
         end
         qbk_pkg::S_KEY: begin
            key_step = 1'b1;
         end
         qbk_pkg::S_EMIT: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.bucket_key    = key_ff;
   assign rsp_bus.left_feature  = lf_ff;
   assign rsp_bus.d0_feature    = d0_out_ff;
   assign rsp_bus.right_feature = rf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qbk_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cut_ok) begin
         case (cut_wr.table_sel)
            qbk_pkg::TABLE_LEFT:  cut_l_ff[IW'(cut_wr.index)] <= cut_wr.value;
            qbk_pkg::TABLE_D0:    cut_0_ff[IW'(cut_wr.index)] <= cut_wr.value;
            qbk_pkg::TABLE_RIGHT: cut_r_ff[IW'(cut_wr.index)] <= cut_wr.value;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         beff_ff <= beff;
         d0_ff   <= head_job.d0;
         idx_ff  <= '0;
         bl_ff   <= '0;
         b0_ff   <= '0;
         br_ff   <= '0;
      end else if (search_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (cut_l_ff[idx_ff[IW-1:0]] <= lf) begin
            bl_ff <= bl_ff + 1'b1;
         end
         if (cut_0_ff[idx_ff[IW-1:0]] <= d0_ff) begin
            b0_ff <= b0_ff + 1'b1;
         end
         if (cut_r_ff[idx_ff[IW-1:0]] <= rf) begin
            br_ff <= br_ff + 1'b1;
         end
      end
      if (key_step) begin
         t_ff <= TW'(bl_ff) * TW'(beff_ff) + TW'(b0_ff);
      end
      if (load_out) begin
         key_ff    <= qbk_pkg::KEY_W'(KW'(t_ff) * KW'(beff_ff) + KW'(br_ff));
         lf_ff     <= lf;
         d0_out_ff <= d0_ff;
         rf_ff     <= rf;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/descriptor_quantile_bucket_key.sv
// ----------------------------------------------------------------------------
// descriptor_quantile_bucket_key
// Streams descriptor elements, forms the left, d0 and right features and the
// combined quantile bucket key for each descriptor.
// ----------------------------------------------------------------------------
// Path from the closing element to its result beat: job queue, two 40-step dividers side
//   by side, B-1 cut compares, key multiply and the output register.
// Throughput: one element beat per cycle, stalled by a full job queue; elements are taken
//   while the back end works; cut writes wait for an empty job queue and an idle back end.
// Reset: registers to 8/1/5/175/179, accumulators and queue cleared; cut tables unset.
`default_nettype none

module descriptor_quantile_bucket_key #(
   parameter int MAX_BUCKETS = qbk_pkg::MAX_BUCKETS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   qbk_req_if.sink    req_bus,
   qbk_rsp_if.source  rsp_bus,
   qbk_csr_if.sink    csr_bus
);

   qbk_pkg::cfg_type           cfg_ff;
   qbk_pkg::job_type           push_job, head_job;
   qbk_pkg::cut_write_type     cut_wr;
   qbk_pkg::queue_status_type  q_status;
   logic                       push, pop, back_idle;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_count <= qbk_pkg::BUCKETS_RST;
         cfg_ff.left_first   <= qbk_pkg::LEFT_FIRST_RST;
         cfg_ff.left_last    <= qbk_pkg::LEFT_LAST_RST;
         cfg_ff.right_first  <= qbk_pkg::RIGHT_FIRST_RST;
         cfg_ff.right_last   <= qbk_pkg::RIGHT_LAST_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            qbk_pkg::CSR_BUCKETS:
               cfg_ff.bucket_count <= csr_bus.data[qbk_pkg::BKT_REG_W-1:0];
            qbk_pkg::CSR_LEFT_FIRST:  cfg_ff.left_first  <= csr_bus.data;
            qbk_pkg::CSR_LEFT_LAST:   cfg_ff.left_last   <= csr_bus.data;
            qbk_pkg::CSR_RIGHT_FIRST: cfg_ff.right_first <= csr_bus.data;
            qbk_pkg::CSR_RIGHT_LAST:  cfg_ff.right_last  <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   qbk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .back_idle (back_idle),
      .push      (push),
      .job       (push_job),
      .cut_wr    (cut_wr)
   );

   qbk_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   qbk_back #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .bucket_count (cfg_ff.bucket_count),
      .head_job     (head_job),
      .q_status     (q_status),
      .cut_wr       (cut_wr),
      .pop          (pop),
      .back_idle    (back_idle),
      .rsp_bus      (rsp_bus)
   );

   a_cut_write_drained: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.cmd) |-> (q_status.empty && back_idle))
      else $error("cut write taken while a descriptor is in flight");

   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job queue popped while empty");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("result beat valid right after reset");

endmodule

`default_nettype wire

>>> tb/descriptor_quantile_bucket_key_checker.sv
// ----------------------------------------------------------------------------
// descriptor_quantile_bucket_key_checker
// Watches the request, register and response channels of the bucket key
// block, keeps its own copy of the window settings, accumulators and cut
// tables, and predicts the key and features that each closing element
// produces. Each response beat is compared field by field with the oldest
// prediction; the failure count and the number of predictions still waiting
// go back to the testbench top.
// ----------------------------------------------------------------------------
module descriptor_quantile_bucket_key_checker (
   input  wire logic clock,
   input  wire logic reset,
   qbk_req_if        req_bus,
   qbk_rsp_if        rsp_bus,
   qbk_csr_if        csr_bus,
   output int        fail_count,
   output int        pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import qbk_pkg::*;

   localparam int TABLES = int'(TABLE_RIGHT) + 1;
   localparam int CUTS   = MAX_BUCKETS_DEF - 1;

   typedef struct packed {
      logic [KEY_W-1:0]        bucket_key;
      logic signed [VAL_W-1:0] left_feature;
      logic signed [VAL_W-1:0] d0_feature;
      logic signed [VAL_W-1:0] right_feature;
   } key_record_type;

   cfg_type                 window_cfg;
   int                      column_pos;
   longint                  left_total;
   longint                  right_total;
   int                      left_hits;
   int                      right_hits;
   logic signed [VAL_W-1:0] d0_seen;
   logic signed [VAL_W-1:0] cut_values [TABLES][CUTS];
   key_record_type          key_queue [$];

   function automatic void restart_descriptor();
      column_pos  = 0;
      left_total  = 0;
      right_total = 0;
      left_hits   = 0;
      right_hits  = 0;
      d0_seen     = '0;
   endfunction

   function automatic int bucket_span();
      int b;
      b = int'(window_cfg.bucket_count);
      if (b < 2) b = 2;
      if (b > MAX_BUCKETS_DEF) b = MAX_BUCKETS_DEF;
      return b;
   endfunction

   function automatic logic signed [VAL_W-1:0] window_mean(longint total, int hits);
      if (hits == 0) return '0;
      return VAL_W'(total / longint'(hits));
   endfunction

   function automatic int cuts_at_or_below(int tsel, logic signed [VAL_W-1:0] feature, int b);
      int n;
      n = 0;
      for (int i = 0; i < b - 1; i++)
         if (cut_values[tsel][i] <= feature) n++;
      return n;
   endfunction

   function automatic void write_register(logic [CSR_IDX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_BUCKETS:     window_cfg.bucket_count = data[BKT_REG_W-1:0];
         CSR_LEFT_FIRST:  window_cfg.left_first = data;
         CSR_LEFT_LAST:   window_cfg.left_last = data;
         CSR_RIGHT_FIRST: window_cfg.right_first = data;
         CSR_RIGHT_LAST:  window_cfg.right_last = data;
         default: ;
      endcase
   endfunction

   function automatic void store_cut(logic [TABLE_W-1:0] tsel, logic [CIDX_W-1:0] tidx,
                                     logic signed [VAL_W-1:0] value);
      if (tsel <= TABLE_RIGHT && int'(tidx) < CUTS) cut_values[tsel][tidx] = value;
   endfunction

   function automatic void absorb_element(logic signed [VAL_W-1:0] value, logic last);
      int                      b;
      int                      key;
      logic signed [VAL_W-1:0] left_mean;
      logic signed [VAL_W-1:0] right_mean;
      if (column_pos < MAX_COLUMNS_DEF) begin
         if (column_pos == 0) d0_seen = value;
         if (value != 0) begin
            if (column_pos >= int'(window_cfg.left_first) &&
                column_pos <= int'(window_cfg.left_last)) begin
               left_total += value;
               left_hits++;
            end
            if (column_pos >= int'(window_cfg.right_first) &&
                column_pos <= int'(window_cfg.right_last)) begin
               right_total += value;
               right_hits++;
            end
         end
         column_pos++;
      end
      if (!last) return;
      b          = bucket_span();
      left_mean  = window_mean(left_total, left_hits);
      right_mean = window_mean(right_total, right_hits);
      key = cuts_at_or_below(int'(TABLE_LEFT), left_mean, b) * b * b
          + cuts_at_or_below(int'(TABLE_D0), d0_seen, b) * b
          + cuts_at_or_below(int'(TABLE_RIGHT), right_mean, b);
      key_queue.insert(key_queue.size(),
                       key_record_type'{KEY_W'(key), left_mean, d0_seen, right_mean});
      restart_descriptor();
   endfunction

   function automatic int field_differs(string name, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
      if (want === got) return 0;
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      return 1;
   endfunction

   function automatic void compare_result(key_record_type got);
      key_record_type want;
      if (key_queue.size() == 0) begin
         $error("bucket_key: no result expected, got 0x%03h", got.bucket_key);
         fail_count++;
         return;
      end
      want = key_queue[0];
      key_queue.delete(0);
      if ((field_differs("bucket_key", VAL_W'(want.bucket_key), VAL_W'(got.bucket_key)) |
           field_differs("left_feature", want.left_feature, got.left_feature) |
           field_differs("d0_feature", want.d0_feature, got.d0_feature) |
           field_differs("right_feature", want.right_feature, got.right_feature)) != 0)
         fail_count++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         window_cfg = '{BUCKETS_RST, LEFT_FIRST_RST, LEFT_LAST_RST,
                        RIGHT_FIRST_RST, RIGHT_LAST_RST};
         restart_descriptor();
         key_queue.delete();
         fail_count      = 0;
         pending_results = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            compare_result(key_record_type'{rsp_bus.bucket_key, rsp_bus.left_feature,
                                            rsp_bus.d0_feature, rsp_bus.right_feature});
         if (csr_bus.valid && csr_bus.ready) write_register(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.cmd)
               store_cut(req_bus.cut_table, req_bus.cut_index, req_bus.value);
            else
               absorb_element(req_bus.value, req_bus.last);
         end
         pending_results = key_queue.size();
      end
   end

endmodule

>>> tb/descriptor_quantile_bucket_key_tb.sv
// ----------------------------------------------------------------------------
// descriptor_quantile_bucket_key_tb
// Drives descriptor elements and cut table writes into the bucket key block
// under several window and bucket settings: a directed opening with extreme
// values, empty windows, truncating means and ignored cut addresses, then
// random descriptors with cut writes mixed in, one overlong descriptor, a
// long response stall and a no-idle stretch. The checker instance predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module descriptor_quantile_bucket_key_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qbk_pkg::*;

   localparam int IDLE_PCT       = 19;
   localparam int LONG_STALL     = 400;
   localparam int SETTLE         = 200;
   localparam int LIMIT          = 400000;
   localparam int PHASES         = 6;
   localparam int STALL_PHASE    = 1;
   localparam int STEADY_PHASE   = 2;
   localparam int OVERLONG_PHASE = 3;
   localparam int PAUSE_PHASE    = 4;
   localparam int PHASE_ITEMS    = 35;
   localparam int TABLES         = int'(TABLE_RIGHT) + 1;
   localparam int CUTS           = MAX_BUCKETS_DEF - 1;

   localparam logic               CMD_ELEMENT = 1'b0;
   localparam logic               CMD_CUT     = 1'b1;
   localparam logic [TABLE_W-1:0] TABLE_NONE  = 2'd3;

   logic clock;
   logic reset;
   bit   steady_flow;
   bit   stall_request;
   int   fail_count;
   int   pending_results;
   int   items_sent;
   bit   cut_loaded [TABLES][CUTS];

   qbk_req_if req_bus ();
   qbk_rsp_if rsp_bus ();
   qbk_csr_if csr_bus ();

   descriptor_quantile_bucket_key dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   descriptor_quantile_bucket_key_checker key_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      repeat (LIMIT) @(posedge clock);
      $display("FAIL descriptor_quantile_bucket_key");
      $finish;
   end

   initial begin : result_pacing
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
         end
         rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return '0;
         3, 4, 5: return VAL_W'(int'($urandom_range(0, 524288)) - 262144);
         6:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int bucket_span(logic [CSR_DATA_W-1:0] code);
      int b;
      b = int'(code[BKT_REG_W-1:0]);
      if (b < 2) b = 2;
      if (b > MAX_BUCKETS_DEF) b = MAX_BUCKETS_DEF;
      return b;
   endfunction

   task automatic offer(input logic cmd, input logic signed [VAL_W-1:0] value,
                        input logic last, input logic [TABLE_W-1:0] tsel,
                        input logic [CIDX_W-1:0] tidx);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.value     <= value;
      req_bus.last      <= last;
      req_bus.cut_table <= tsel;
      req_bus.cut_index <= tidx;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic add_element(input logic signed [VAL_W-1:0] value, input logic last);
      offer(CMD_ELEMENT, value, last, TABLE_W'($urandom), CIDX_W'($urandom));
   endtask

   task automatic load_cut(input logic [TABLE_W-1:0] tsel, input logic [CIDX_W-1:0] tidx,
                           input logic signed [VAL_W-1:0] value);
      offer(CMD_CUT, value, 1'($urandom), tsel, tidx);
      if (tsel <= TABLE_RIGHT && int'(tidx) < CUTS) cut_loaded[tsel][tidx] = 1'b1;
   endtask

   task automatic fill_cuts(input int b);
      for (int t = 0; t < TABLES; t++)
         for (int i = 0; i < b - 1; i++)
            if (!cut_loaded[t][i]) load_cut(TABLE_W'(t), CIDX_W'(i), pick_value());
   endtask

   task automatic send_descriptor(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 6)
            load_cut(TABLE_W'($urandom), CIDX_W'($urandom), pick_value());
         add_element(pick_value(), i == len - 1);
      end
   endtask

   task automatic run_stream(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0)
            load_cut(TABLE_W'($urandom), CIDX_W'($urandom), pick_value());
         else
            send_descriptor($urandom_range(1, 26));
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      wait (pending_results == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] buckets,
                            input logic [CSR_DATA_W-1:0] left_first,
                            input logic [CSR_DATA_W-1:0] left_last,
                            input logic [CSR_DATA_W-1:0] right_first,
                            input logic [CSR_DATA_W-1:0] right_last);
      logic [CSR_IDX_W-1:0]  regs [5];
      logic [CSR_DATA_W-1:0] data [5];
      regs = '{CSR_BUCKETS, CSR_LEFT_FIRST, CSR_LEFT_LAST, CSR_RIGHT_FIRST, CSR_RIGHT_LAST};
      data = '{buckets, left_first, left_last, right_first, right_last};
      for (int i = 0; i < 5; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= regs[i];
         csr_bus.data  <= data[i];
         do @(posedge clock); while (!csr_bus.ready);
         @(negedge clock);
      end
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] bucket_codes [PHASES];
      bucket_codes      = '{8'hF0, 8'd8, 8'h0F, 8'd2, 8'h39, 8'd1};
      reset             = 1'b1;
      steady_flow       = 1'b0;
      stall_request     = 1'b0;
      items_sent        = 0;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_ELEMENT;
      req_bus.value     = '0;
      req_bus.last      = 1'b0;
      req_bus.cut_table = TABLE_LEFT;
      req_bus.cut_index = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_BUCKETS;
      csr_bus.data      = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      configure(8'd4, 8'd1, 8'd3, 8'd4, 8'd6);
      load_cut(TABLE_LEFT, 3'd0, -1000);
      load_cut(TABLE_LEFT, 3'd1, 0);
      load_cut(TABLE_LEFT, 3'd2, 1000);
      load_cut(TABLE_D0, 3'd0, 32'sh80000000);
      load_cut(TABLE_D0, 3'd1, 0);
      load_cut(TABLE_D0, 3'd2, 32'sh7fffffff);
      load_cut(TABLE_RIGHT, 3'd0, -5);
      load_cut(TABLE_RIGHT, 3'd1, 5);
      load_cut(TABLE_RIGHT, 3'd2, 5);
      load_cut(TABLE_NONE, 3'd0, 0);
      load_cut(TABLE_D0, CIDX_W'(CUTS), 12345);
      add_element(32'sh7fffffff, 1'b1);
      add_element(32'sh80000000, 1'b0);
      add_element(0, 1'b0);
      add_element(0, 1'b0);
      add_element(0, 1'b1);
      add_element(5, 1'b0);
      add_element(32'sh80000000, 1'b0);
      add_element(32'sh80000000, 1'b0);
      add_element(-3, 1'b0);
      load_cut(TABLE_RIGHT, 3'd2, 32'sh7ffffff0);
      add_element(32'sh7fffffff, 1'b0);
      add_element(32'sh7fffffff, 1'b0);
      add_element(32'sh7ffffffe, 1'b1);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         if (p == OVERLONG_PHASE)
            configure(bucket_codes[p], 8'd0, 8'd255, 8'd250, 8'd255);
         else
            configure(bucket_codes[p], 8'($urandom_range(0, 10)), 8'($urandom_range(0, 16)),
                      8'($urandom_range(0, 20)), 8'($urandom_range(0, 24)));
         fill_cuts(bucket_span(bucket_codes[p]));
         steady_flow = (p == STEADY_PHASE);
         if (p == STALL_PHASE) stall_request = 1'b1;
         if (p == OVERLONG_PHASE) begin
            send_descriptor($urandom_range(257, 264));
            run_stream(20);
         end else if (p == PAUSE_PHASE) begin
            run_stream(PHASE_ITEMS / 2);
            req_bus.valid <= 1'b0;
            wait (pending_results == 0);
            @(negedge clock);
            run_stream(PHASE_ITEMS / 2);
         end else begin
            run_stream(PHASE_ITEMS);
         end
         drain();
      end

      if (fail_count == 0 && pending_results == 0)
         $display("PASS descriptor_quantile_bucket_key");
      else
         $display("FAIL descriptor_quantile_bucket_key");
      $finish;
   end

endmodule
